/* rtl/srbs_pkg.sv */
// srbs_pkg: shared constants, codes and record compare helpers for the
// sorted record store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srbs_pkg;

  localparam int unsigned DEF_MAX_RECORDS = 1024;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned REC_W           = 128;

  // command codes
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_SORT   = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_LOWER  = 3'd4;
  localparam logic [2:0] CMD_UPPER  = 3'd5;
  localparam logic [2:0] CMD_READ   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // register indexes
  localparam logic [1:0] REG_KEY_BYTES = 2'd0;
  localparam logic [1:0] REG_VAL_BYTES = 2'd1;
  localparam logic [1:0] REG_CAPACITY  = 2'd2;

  typedef logic [REC_W-1:0] rec_t;

  // keep the low n bytes of a word
  function automatic logic [KEY_W-1:0] mask_bytes(logic [KEY_W-1:0] w, logic [3:0] n);
    logic [KEY_W-1:0] r;
    if (n >= 4'd8) begin
      r = w;
    end else begin
      r = w & ((64'd1 << {n[2:0], 3'b000}) - 64'd1);
    end
    return r;
  endfunction

  // record as a left-aligned byte string: key bytes, then value bytes, then zeros
  function automatic rec_t rec_align(logic [KEY_W-1:0] k, logic [KEY_W-1:0] v,
                                     logic [3:0] kb, logic [3:0] vb);
    logic [KEY_W-1:0] km;
    logic [KEY_W-1:0] vm;
    logic [KEY_W-1:0] kt;
    logic [KEY_W-1:0] vt;
    km = mask_bytes(k, kb);
    vm = mask_bytes(v, vb);
    kt = km << {(4'd8 - kb), 3'b000};
    vt = vm << {(4'd8 - vb), 3'b000};
    return {kt, 64'd0} | ({vt, 64'd0} >> {kb, 3'b000});
  endfunction

  // mask covering the leading n bytes of an aligned record
  function automatic rec_t prefix_mask(logic [4:0] n);
    return ~({REC_W{1'b1}} >> {n, 3'b000});
  endfunction

endpackage
`default_nettype wire

/* rtl/srbs_mem.sv */
// srbs_mem: key and value record memories, one write and one registered read
// per cycle. Depends on srbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srbs_mem #(
  parameter int unsigned MAX_RECORDS = srbs_pkg::DEF_MAX_RECORDS,
  parameter int unsigned AW          = $clog2(MAX_RECORDS)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [srbs_pkg::KEY_W-1:0] wr_key,
  input  wire logic [srbs_pkg::KEY_W-1:0] wr_val,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [srbs_pkg::KEY_W-1:0] rd_key,
  output logic      [srbs_pkg::KEY_W-1:0] rd_val
);
  import srbs_pkg::*;

  logic [KEY_W-1:0] key_mem [MAX_RECORDS];
  logic [KEY_W-1:0] val_mem [MAX_RECORDS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/sorted_record_block_search.sv */
// Clear, append and unused commands answer straight from idle; read fetches the record
// (S_FETCH, S_FETCH_WT); find and bounds run a binary search, then fetch the record if in range.
// Sort is an insertion sort: each record is read and held, and larger records shift up until it is placed.
// One command at a time; every step is bound by the single memory read port.
// Reset (rst_n, synchronous): store empty, unsorted, registers at defaults;
// record memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_record_block_search #(
  parameter int unsigned MAX_RECORDS = srbs_pkg::DEF_MAX_RECORDS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [10:0]  cfg_wr_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // key_word[63:0], value_word[127:64], prefix_bytes[132:128], read_index[142:133]
  input  wire logic [143:0] in_tdata,
  // command[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // position[10:0], remaining[21:11], record_total[32:22], is_sorted[33],
  // key_out[97:34], value_out[161:98]
  output logic [167:0]      out_tdata,
  // status[1:0]
  output logic [1:0]        out_tuser
);
  import srbs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned PW = (CW > 11) ? CW : 11;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH     = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_FETCH    = 4'd3;
  localparam logic [3:0] S_FETCH_WT = 4'd4;
  localparam logic [3:0] S_SORT_RDI = 4'd5;
  localparam logic [3:0] S_SORT_LDI = 4'd6;
  localparam logic [3:0] S_SORT_RDJ = 4'd7;
  localparam logic [3:0] S_SORT_CMP = 4'd8;

  // input beat fields
  logic [63:0] in_key, in_val;
  logic [4:0]  in_prefix;
  logic [9:0]  in_ridx;
  logic [2:0]  in_cmd;
  assign in_key    = in_tdata[63:0];
  assign in_val    = in_tdata[127:64];
  assign in_prefix = in_tdata[132:128];
  assign in_ridx   = in_tdata[142:133];
  assign in_cmd    = in_tuser;

  logic [3:0]  kb_r, vb_r;
  logic [10:0] cap_r;
  logic [3:0]  state_r, state_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  rec_t        probe_r, probe_nxt, pmask_r, pmask_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, count_r, count_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [63:0]   hold_k_r, hold_k_nxt, hold_v_r, hold_v_nxt;
  logic          sorted_r, sorted_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [10:0]   out_pos_r, out_rem_r, out_total_r;
  logic          out_sorted_r;
  logic [63:0]   out_key_r, out_val_r;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [63:0]   mem_wr_key, mem_wr_val, mem_rd_key, mem_rd_val;

  // result to load
  logic          res_load, res_has;
  logic [1:0]    res_status;
  logic [PW-1:0] res_pos, res_rem;
  logic [63:0]   res_key, res_val;

  logic [3:0]    kbe, vbe;
  logic [4:0]    reclen, plen;
  logic          in_acc;
  rec_t          rd_rec, rd_cmp;
  logic          rd_lt, rd_eq;
  logic          full;

  assign kbe    = (kb_r == 4'd0) ? 4'd1 : ((kb_r > 4'd8) ? 4'd8 : kb_r);
  assign vbe    = (vb_r > 4'd8) ? 4'd8 : vb_r;
  assign reclen = 5'(kbe) + 5'(vbe);
  assign plen   = (in_prefix > reclen) ? reclen : in_prefix;
  assign in_acc = in_tvalid && in_tready;
  assign full   = (32'(count_r) >= 32'(cap_r)) || (32'(count_r) >= 32'(MAX_RECORDS));

  // compare the record just read against the held probe
  assign rd_rec = rec_align(mem_rd_key, mem_rd_val, kbe, vbe);
  assign rd_cmp = rd_rec & pmask_r;
  assign rd_lt  = rd_cmp < probe_r;
  assign rd_eq  = rd_cmp == probe_r;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_r  <= 4'd8;
      vb_r  <= 4'd0;
      cap_r <= 11'd1024;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KEY_BYTES: kb_r  <= cfg_wr_data[3:0];
        REG_VAL_BYTES: vb_r  <= cfg_wr_data[3:0];
        REG_CAPACITY:  cap_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    probe_nxt  = probe_r;
    pmask_nxt  = pmask_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pos_nxt    = pos_r;
    hold_k_nxt = hold_k_r;
    hold_v_nxt = hold_v_r;
    count_nxt  = count_r;
    sorted_nxt = sorted_r;
    mem_we      = 1'b0;
    mem_wr_addr = count_r[AW-1:0];
    mem_wr_key  = hold_k_r;
    mem_wr_val  = hold_v_r;
    mem_rd_addr = pos_r[AW-1:0];
    res_load   = 1'b0;
    res_has    = 1'b0;
    res_status = ST_OK;
    res_pos    = '0;
    res_key    = mem_rd_key;
    res_val    = mem_rd_val;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_cmd;
          pmask_nxt = prefix_mask(plen);
          probe_nxt = rec_align(in_key, in_val, kbe, vbe) & prefix_mask(plen);
          lo_nxt    = '0;
          hi_nxt    = count_r;
          case (in_cmd)
            CMD_CLEAR: begin
              count_nxt  = '0;
              sorted_nxt = 1'b0;
              res_load   = 1'b1;
            end
            CMD_APPEND: begin
              res_load = 1'b1;
              res_pos  = PW'(count_r);
              if (full) begin
                res_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wr_key = mask_bytes(in_key, kbe);
                mem_wr_val = mask_bytes(in_val, vbe);
                count_nxt  = count_r + 1'b1;
                sorted_nxt = 1'b0;
                res_has    = 1'b1;
                res_key    = mem_wr_key;
                res_val    = mem_wr_val;
              end
            end
            CMD_SORT: begin
              if (sorted_r || count_r <= CW'(1)) begin
                sorted_nxt = 1'b1;
                res_load   = 1'b1;
              end else begin
                i_nxt     = CW'(1);
                state_nxt = S_SORT_RDI;
              end
            end
            CMD_FIND, CMD_LOWER, CMD_UPPER: state_nxt = S_SRCH;
            CMD_READ: begin
              pos_nxt = PW'(in_ridx);
              if (32'(in_ridx) < 32'(count_r)) begin
                state_nxt = S_FETCH;
              end else begin
                res_load   = 1'b1;
                res_status = ST_RANGE;
                res_pos    = PW'(in_ridx);
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end

      // binary search: issue read of the midpoint
      S_SRCH: begin
        mid_nxt     = lo_r + ((hi_r - lo_r) >> 1);
        mem_rd_addr = mid_nxt[AW-1:0];
        if (lo_r < hi_r) begin
          state_nxt = S_SRCH_CMP;
        end else begin
          pos_nxt = PW'(lo_r);
          if (lo_r < count_r) begin
            state_nxt = S_FETCH;
          end else begin
            res_load   = 1'b1;
            res_pos    = PW'(lo_r);
            res_status = (cmd_r == CMD_FIND) ? ST_NOT_FOUND : ST_OK;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_SRCH_CMP: begin
        if (rd_lt || (cmd_r == CMD_UPPER && rd_eq)) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end

      S_FETCH: begin
        mem_rd_addr = pos_r[AW-1:0];
        state_nxt   = S_FETCH_WT;
      end

      // record at pos is in the read register
      S_FETCH_WT: begin
        res_load  = 1'b1;
        res_pos   = pos_r;
        res_has   = 1'b1;
        state_nxt = S_IDLE;
        if (cmd_r == CMD_FIND && !rd_eq) begin
          res_has    = 1'b0;
          res_status = ST_NOT_FOUND;
        end
      end

      // insertion sort: fetch record i
      S_SORT_RDI: begin
        mem_rd_addr = i_r[AW-1:0];
        state_nxt   = S_SORT_LDI;
      end

      S_SORT_LDI: begin
        hold_k_nxt = mem_rd_key;
        hold_v_nxt = mem_rd_val;
        pmask_nxt  = prefix_mask(reclen);
        probe_nxt  = rd_rec & prefix_mask(reclen);
        j_nxt      = i_r;
        state_nxt  = S_SORT_RDJ;
      end

      // read j-1, or drop the held record at slot 0
      S_SORT_RDJ: begin
        mem_rd_addr = AW'(j_r - 1'b1);
        if (j_r == '0) begin
          mem_we      = 1'b1;
          mem_wr_addr = j_r[AW-1:0];
          i_nxt       = i_r + 1'b1;
          state_nxt   = (i_nxt >= count_r) ? S_IDLE : S_SORT_RDI;
        end else begin
          state_nxt = S_SORT_CMP;
        end
      end

      // shift record j-1 up or place the held record at j
      S_SORT_CMP: begin
        mem_we      = 1'b1;
        mem_wr_addr = j_r[AW-1:0];
        if (!rd_lt && !rd_eq) begin
          mem_wr_key = mem_rd_key;
          mem_wr_val = mem_rd_val;
          j_nxt      = j_r - 1'b1;
          state_nxt  = S_SORT_RDJ;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_nxt >= count_r) ? S_IDLE : S_SORT_RDI;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // sort completion
    if ((state_r == S_SORT_RDJ || state_r == S_SORT_CMP) && state_nxt == S_IDLE) begin
      sorted_nxt = 1'b1;
      res_load   = 1'b1;
    end

    res_rem = (res_pos <= PW'(count_nxt)) ? (PW'(count_nxt) - res_pos) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      sorted_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sorted_r <= sorted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    probe_r  <= probe_nxt;
    pmask_r  <= pmask_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pos_r    <= pos_nxt;
    hold_k_r <= hold_k_nxt;
    hold_v_r <= hold_v_nxt;
  end

  // output register
  assign out_valid_nxt = res_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_pos_r    <= 11'(res_pos);
      out_rem_r    <= 11'(res_rem);
      out_total_r  <= 11'(count_nxt);
      out_sorted_r <= sorted_nxt;
      out_key_r    <= res_has ? mask_bytes(res_key, kbe) : 64'd0;
      out_val_r    <= res_has ? mask_bytes(res_val, vbe) : 64'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_val_r, out_key_r, out_sorted_r, out_total_r,
                       out_rem_r, out_pos_r};

  srbs_mem #(
    .MAX_RECORDS (MAX_RECORDS),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_key  (mem_wr_key),
    .wr_val  (mem_wr_val),
    .rd_addr (mem_rd_addr),
    .rd_key  (mem_rd_key),
    .rd_val  (mem_rd_val)
  );

`ifndef SYNTHESIS
  // count never passes the store depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_RECORDS))
    else $error("record count above depth");

  // memory writes only on an append beat or inside a sort
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_acc || state_r == S_SORT_RDJ || state_r == S_SORT_CMP))
    else $error("stray memory write");

  // no new beat taken while a command is in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input ready while busy");

  // a sort that finishes from the compare state leaves the store flagged sorted
  a_sort_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_CMP && state_nxt == S_IDLE) |=> sorted_r)
    else $error("sort finished without flag");
`endif

endmodule
`default_nettype wire
